// ----- rtl/mrs_pkg.sv -----
// shared types and constants of the monotone run segmenter
// no dependencies; imported by the core and its checker
package mrs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int RUN_LENGTH_BITS = 16;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef enum logic [1:0] {
        DIR_UP   = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_NONE = 2'd2
    } dir_t;

    typedef struct packed {
        dir_t                       direction;
        logic [RUN_LENGTH_BITS-1:0] run_length;
        logic                       length_saturated;
        logic                       end_of_sequence;
    } result_t;

endpackage

// ----- rtl/monotone_run_segmenter_core.sv -----
// monotone run segmenter: run tracking state and a small result queue
// depends on mrs_pkg
//
// usage
//   input channel: sample and final_sample with in_valid / in_ready. each accepted
//   request is compared with the previous sample; a sample that breaks the run
//   direction closes the run and produces one result, a sample with final_sample
//   set flushes the open run and produces one result, both together produce two
//   (the closed run first, then the one-sample run with end_of_sequence set).
//   output channel: direction, run_length, length_saturated, end_of_sequence
//   with out_valid / out_ready, driven from a four-entry result queue.
//   results are registered in the queue and offered from its head, behind any results ahead of them.
//   throughput: one sample per cycle while every sample gives at most one result and
//   the receiver takes each result; a sample giving two results adds two queue entries.
//   the rate is set by the single result port draining the queue.
//   in_ready is high while the queue has room for two results, so a stalled
//   receiver only holds back the input once fewer than two entries are free; nothing is lost.
//   reset clears the run state (no run open) and empties the queue.
module monotone_run_segmenter_core #(
    parameter int SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = mrs_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 final_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           direction,
    output logic [mrs_pkg::RUN_LENGTH_BITS-1:0]  run_length,
    output logic                                 length_saturated,
    output logic                                 end_of_sequence
);
    import mrs_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // run state
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic                          open_reg;
    dir_t                          dir_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic                          sat_reg;

    logic signed [SAMPLE_BITS-1:0] prev_next;
    logic                          open_next;
    dir_t                          dir_next;
    logic [COUNT_BITS-1:0]         count_next;
    logic                          sat_next;

    // result queue
    result_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] fill_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] fill_next;

    logic                  accept;
    logic                  pop;
    logic                  extend;
    logic                  brk;
    dir_t                  dir_ext;
    logic [COUNT_BITS-1:0] count_ext;
    result_t               res_brk;
    result_t               res_fin;
    result_t               res_first;
    logic [QCNT_BITS-1:0]  n_push;

    assign accept   = in_valid && in_ready;
    assign pop      = out_valid && out_ready;
    assign in_ready = fill_reg <= QCNT_BITS'(QUEUE_DEPTH - 2);

    assign count_ext = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // run decision for the incoming sample
    always_comb
    begin
        extend  = 1'b0;
        brk     = 1'b0;
        dir_ext = dir_reg;
        if (open_reg)
        begin
            case (dir_reg)
                DIR_UP:
                begin
                    extend = sample >= prev_reg;
                    brk    = !extend;
                end
                DIR_DOWN:
                begin
                    extend = sample <= prev_reg;
                    brk    = !extend;
                end
                default:
                begin
                    extend = 1'b1;
                    if (sample > prev_reg)
                        dir_ext = DIR_UP;
                    else if (sample < prev_reg)
                        dir_ext = DIR_DOWN;
                    else
                        dir_ext = DIR_NONE;
                end
            endcase
        end
    end

    // results and next run state
    always_comb
    begin
        res_brk.direction        = dir_reg;
        res_brk.run_length       = RUN_LENGTH_BITS'(count_reg);
        res_brk.length_saturated = sat_reg;
        res_brk.end_of_sequence  = 1'b0;

        prev_next = prev_reg;
        open_next = open_reg;
        dir_next  = dir_reg;
        count_next = count_reg;
        sat_next  = sat_reg;

        if (accept)
        begin
            prev_next = sample;
            if (extend)
            begin
                dir_next   = dir_ext;
                count_next = count_ext;
                sat_next   = count_ext == COUNT_MAX;
            end
            else
            begin
                // fresh run of one sample
                open_next  = 1'b1;
                dir_next   = DIR_NONE;
                count_next = COUNT_BITS'(1);
                sat_next   = 1'b0;
            end
        end

        res_fin.direction        = dir_next;
        res_fin.run_length       = RUN_LENGTH_BITS'(count_next);
        res_fin.length_saturated = sat_next;
        res_fin.end_of_sequence  = 1'b1;

        if (accept && final_sample)
        begin
            open_next  = 1'b0;
            dir_next   = DIR_NONE;
            count_next = '0;
            sat_next   = 1'b0;
        end

        res_first = brk ? res_brk : res_fin;
        n_push    = accept ? QCNT_BITS'({1'b0, brk} + {1'b0, final_sample}) : '0;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + n_push - QCNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            open_reg   <= 1'b0;
            dir_reg    <= DIR_NONE;
            count_reg  <= '0;
            sat_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            prev_reg   <= prev_next;
            open_reg   <= open_next;
            dir_reg    <= dir_next;
            count_reg  <= count_next;
            sat_reg    <= sat_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (n_push != '0)
            queue_reg[wr_ptr_reg] <= res_first;
        if (n_push == QCNT_BITS'(2))
            queue_reg[wr_ptr_reg + 1'b1] <= res_fin;
    end

    assign out_valid        = fill_reg != '0;
    assign direction        = queue_reg[rd_ptr_reg].direction;
    assign run_length       = queue_reg[rd_ptr_reg].run_length;
    assign length_saturated = queue_reg[rd_ptr_reg].length_saturated;
    assign end_of_sequence  = queue_reg[rd_ptr_reg].end_of_sequence;

endmodule

// ----- rtl/mrs_checker.sv -----
// port-level checks of the monotone run segmenter, bound to the core
// depends on mrs_pkg and monotone_run_segmenter_core
module mrs_checker #(
    parameter int SAMPLE_BITS = mrs_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = mrs_pkg::COUNT_BITS_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic signed [SAMPLE_BITS-1:0]        sample,
    input logic                                 final_sample,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [1:0]                           direction,
    input logic [mrs_pkg::RUN_LENGTH_BITS-1:0]  run_length,
    input logic                                 length_saturated,
    input logic                                 end_of_sequence
);
    import mrs_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [RUN_LENGTH_BITS-1:0] SAT_LENGTH = RUN_LENGTH_BITS'(COUNT_MAX);

    // a waiting request stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(sample) && $stable(final_sample))
        else $error("waiting request changed");

    // a stalled result stays offered and unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(direction)
            && $stable(run_length) && $stable(length_saturated)
            && $stable(end_of_sequence))
        else $error("stalled result changed");

    // a final sample always leaves a result behind for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && final_sample |=> out_valid)
        else $error("final request gave no result");

    // a run closed by a break always had a decided direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_of_sequence |-> direction != DIR_NONE)
        else $error("break result with undecided direction");

    // saturation flag only with the counter at its maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_saturated |-> run_length == SAT_LENGTH)
        else $error("saturated flag with wrong length");

endmodule

bind monotone_run_segmenter_core mrs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_mrs_checker (.*);
